### rtl/mf3_pkg.sv
// Package for the 3x3 median filter: pixel and sample types, register indexes
// and the small compare helpers used by the sorting stages. No dependencies.
package mf3_pkg;

  localparam int unsigned PIX_W  = 32;
  localparam int unsigned SMP_W  = 8;
  localparam int unsigned NUM_CH = 4;

  localparam logic [1:0] REG_WIDTH    = 2'd0;
  localparam logic [1:0] REG_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_CHANNELS = 2'd2;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [SMP_W-1:0] smp_t;

  typedef struct packed {
    smp_t lo;
    smp_t md;
    smp_t hi;
  } trio_t;

  // Control travelling with an item down the pipeline.
  typedef struct packed {
    logic valid;    // item yields a result beat
    logic wr;       // pixel that updates the line buffers and window
    logic flush;    // drain beat read from the line buffers
    logic sel_new;  // drain beat takes the newer line
    logic echo;     // small frame: pixel passes straight through
    logic med;      // interior pixel: filtered
    logic last;     // final pixel of the frame
  } ctl_t;

  function automatic smp_t min2(smp_t a, smp_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic smp_t max2(smp_t a, smp_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic trio_t sort3(smp_t a, smp_t b, smp_t c);
    trio_t t;
    t.lo = min2(min2(a, b), c);
    t.hi = max2(max2(a, b), c);
    t.md = max2(min2(a, b), min2(max2(a, b), c));
    return t;
  endfunction

endpackage

### rtl/mf3_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; used for the line buffers of the median filter.
module mf3_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd <= mem[ra];
    end
  end

endmodule

### rtl/median_filter_3x3.sv
// 3x3 median filter on a raster pixel stream, top level.
// Depends on mf3_pkg and mf3_ram.
//
// The block takes one beat per clock, pixel or flush, when the output is not
// stalled, and passes each beat through the stage registers s1, s2, s3 and
// the output register; the sustained rate is likewise one beat per cycle,
// set by the single line-buffer RAM which is read and written once for
// each pixel. Results lag the input stream by one row plus one pixel, so once
// the last pixel of a frame is in, width+1 flush beats (tuser high) drain the
// remaining pixels. Border pixels pass through; the first channel_count
// channels of interior pixels take the median of their 3x3 neighbourhood.
// With a width or height below 3 each pixel is echoed and flushes give
// nothing. The whole pipeline moves only when the output register is free or
// being taken, so in_tready follows out_tready.
module median_filter_3x3 #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // chan_zero, chan_one, chan_two, chan_three
  input  logic        in_tuser,   // kind
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // res_zero, res_one, res_two, res_three
  output logic        out_tlast   // frame_last
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = AW + 1;
  localparam int WW = (CW > 12) ? CW : 12;

  // Configuration registers.
  logic [11:0] fw_r;
  logic [15:0] fh_r;
  logic [2:0]  cc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= 12'd640;
      fh_r <= 16'd480;
      cc_r <= 3'd4;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        mf3_pkg::REG_WIDTH:    fw_r <= cfg_wdata[11:0];
        mf3_pkg::REG_HEIGHT:   fh_r <= cfg_wdata;
        mf3_pkg::REG_CHANNELS: cc_r <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // Effective width is clamped to the line buffer depth.
  logic [WW-1:0] fw_ext;
  logic [CW-1:0] eff_w;
  logic          tiny_frame;

  assign fw_ext     = WW'(fw_r);
  assign eff_w      = (fw_ext > WW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(fw_ext);
  assign tiny_frame = (eff_w < CW'(3)) || (fh_r < 16'd3);

  // Pipeline advance: the output register is empty or being taken.
  logic adv;
  logic out_valid_r;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  logic acc;
  assign acc = in_tvalid && adv;

  // Stage 0: position counters and the decision on what the beat does.
  logic [CW-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [15:0]   in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  mf3_pkg::ctl_t ctl0;
  logic [AW-1:0] addr0;
  logic [CW-1:0] x, x1;
  logic [15:0]   y, y1;
  logic          olast, ointer, emit;

  always_comb begin
    ctl0        = '0;
    addr0       = in_col_r[AW-1:0];
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    x           = in_col_r;
    y           = in_row_r;
    x1          = in_col_r;
    y1          = in_row_r;
    emit        = 1'b0;
    olast  = ({1'b0, out_row_r} + 17'd1 >= {1'b0, fh_r}) &&
             ({1'b0, out_col_r} + (CW+1)'(1) >= {1'b0, eff_w});
    ointer = (out_row_r != 16'd0) && ({1'b0, out_row_r} + 17'd1 < {1'b0, fh_r}) &&
             (out_col_r != '0) && ({1'b0, out_col_r} + (CW+1)'(1) < {1'b0, eff_w});
    if (tiny_frame) begin
      if (!in_tuser) begin
        ctl0.valid = 1'b1;
        ctl0.echo  = 1'b1;
        ctl0.last  = ({1'b0, in_col_r} + (CW+1)'(1) >= {1'b0, eff_w}) &&
                     ({1'b0, in_row_r} + 17'd1 >= {1'b0, fh_r});
        x1 = in_col_r + CW'(1);
        if (x1 >= eff_w) begin
          x1 = '0;
          y1 = in_row_r + 16'd1;
          if ({1'b0, in_row_r} + 17'd1 >= {1'b0, fh_r}) begin
            y1 = 16'd0;
          end
        end
        in_col_nxt  = x1;
        in_row_nxt  = y1;
        out_col_nxt = '0;
        out_row_nxt = 16'd0;
        if (ctl0.last) begin
          in_col_nxt = '0;
          in_row_nxt = 16'd0;
        end
      end
    end else begin
      if (in_tuser) begin
        if (in_row_r >= fh_r) begin
          ctl0.valid   = 1'b1;
          ctl0.flush   = 1'b1;
          ctl0.sel_new = ({1'b0, out_row_r} + 17'd1 >= {1'b0, fh_r});
          ctl0.last    = olast;
          addr0        = out_col_r[AW-1:0];
        end
      end else if (in_row_r < fh_r) begin
        if (x >= eff_w) begin
          x = '0;
          y = in_row_r + 16'd1;
        end
        ctl0.wr = 1'b1;
        addr0   = x[AW-1:0];
        emit    = ((y >= 16'd1) && (x >= CW'(1))) || (y >= 16'd2);
        x1      = x + CW'(1);
        y1      = y;
        if (x1 >= eff_w) begin
          x1 = '0;
          y1 = y + 16'd1;
        end
        in_col_nxt = x1;
        in_row_nxt = y1;
        ctl0.valid = emit;
        ctl0.med   = emit && ointer;
        ctl0.last  = emit && olast;
      end
      if (ctl0.valid) begin
        if (olast) begin
          in_col_nxt  = '0;
          in_row_nxt  = 16'd0;
          out_col_nxt = '0;
          out_row_nxt = 16'd0;
        end else if ({1'b0, out_col_r} + (CW+1)'(1) >= {1'b0, eff_w}) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + 16'd1;
        end else begin
          out_col_nxt = out_col_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else if (acc) begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  // Line buffers: one word holds the older line (high half) and newer line.
  mf3_pkg::ctl_t  s1_ctl_r;
  mf3_pkg::pix_t  s1_pix_r;
  logic [AW-1:0]  s1_addr_r;
  logic           fwd_r;
  logic [63:0]    fwd_data_r;
  logic [63:0]    ram_rd, line1, wdata;
  logic           ram_re, ram_we;
  logic           fwd_hit;

  assign ram_re  = acc && (ctl0.wr || ctl0.flush);
  assign ram_we  = adv && s1_ctl_r.wr;
  assign line1   = fwd_r ? fwd_data_r : ram_rd;
  assign wdata   = {line1[31:0], s1_pix_r};
  // A drain beat may read the entry that the pixel ahead of it is writing.
  assign fwd_hit = ram_we && ram_re && (s1_addr_r == addr0);

  mf3_ram #(
    .WIDTH (64),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk (clk),
    .we  (ram_we),
    .wa  (s1_addr_r),
    .wd  (wdata),
    .re  (ram_re),
    .ra  (addr0),
    .rd  (ram_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
      fwd_r    <= 1'b0;
    end else if (adv) begin
      s1_ctl_r <= acc ? ctl0 : '0;
      fwd_r    <= fwd_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pix_r   <= in_tdata;
      s1_addr_r  <= addr0;
      fwd_data_r <= wdata;
    end
  end

  // Stage 1: window shift; each column holds top, middle and bottom samples.
  logic [2:0][31:0] colb_r, colc_r;
  logic [2:0][31:0] newcol;

  assign newcol = {s1_pix_r, line1[31:0], line1[63:32]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      colb_r <= '0;
      colc_r <= '0;
    end else if (adv && s1_ctl_r.wr) begin
      colb_r <= colc_r;
      colc_r <= newcol;
    end
  end

  mf3_pkg::ctl_t          s2_ctl_r;
  mf3_pkg::pix_t          s2_val_r;
  logic [2:0][2:0][31:0]  s2_win_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctl_r <= '0;
    end else if (adv) begin
      s2_ctl_r <= s1_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_win_r <= {newcol, colc_r, colb_r};
      if (s1_ctl_r.echo) begin
        s2_val_r <= s1_pix_r;
      end else if (s1_ctl_r.flush) begin
        s2_val_r <= s1_ctl_r.sel_new ? line1[31:0] : line1[63:32];
      end else begin
        s2_val_r <= colc_r[1];
      end
    end
  end

  // Stage 2: sort each column of each channel.
  mf3_pkg::ctl_t               s3_ctl_r;
  mf3_pkg::pix_t               s3_val_r;
  mf3_pkg::trio_t [3:0][2:0]   s3_sort_r;
  mf3_pkg::trio_t [3:0][2:0]   sort_nxt;

  always_comb begin
    for (int c = 0; c < mf3_pkg::NUM_CH; c++) begin
      for (int k = 0; k < 3; k++) begin
        sort_nxt[c][k] = mf3_pkg::sort3(s2_win_r[k][0][8*c +: 8],
                                        s2_win_r[k][1][8*c +: 8],
                                        s2_win_r[k][2][8*c +: 8]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_ctl_r <= '0;
    end else if (adv) begin
      s3_ctl_r <= s2_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_val_r  <= s2_val_r;
      s3_sort_r <= sort_nxt;
    end
  end

  // Stage 3: median is the median of max-of-lows, median-of-middles and
  // min-of-highs.
  mf3_pkg::pix_t res;
  mf3_pkg::smp_t a_lo, b_md, c_hi;
  mf3_pkg::trio_t m3, mm;

  always_comb begin
    res  = s3_val_r;
    a_lo = '0;
    b_md = '0;
    c_hi = '0;
    m3   = '0;
    mm   = '0;
    for (int c = 0; c < mf3_pkg::NUM_CH; c++) begin
      a_lo = mf3_pkg::max2(mf3_pkg::max2(s3_sort_r[c][0].lo, s3_sort_r[c][1].lo),
                           s3_sort_r[c][2].lo);
      c_hi = mf3_pkg::min2(mf3_pkg::min2(s3_sort_r[c][0].hi, s3_sort_r[c][1].hi),
                           s3_sort_r[c][2].hi);
      m3   = mf3_pkg::sort3(s3_sort_r[c][0].md, s3_sort_r[c][1].md, s3_sort_r[c][2].md);
      b_md = m3.md;
      mm   = mf3_pkg::sort3(a_lo, b_md, c_hi);
      if (s3_ctl_r.med && (3'(c) < cc_r)) begin
        res[8*c +: 8] = mm.md;
      end
    end
  end

  logic [31:0] out_data_r;
  logic        out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s3_ctl_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= res;
      out_last_r <= s3_ctl_r.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // A read of the entry being written must take the forwarded word.
  a_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_hit |=> fwd_r)
    else $error("line buffer collision not forwarded");

  // The last pixel of a frame is a corner and never filtered.
  a_last_border: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_ctl_r.valid && s3_ctl_r.med) |-> !s3_ctl_r.last)
    else $error("filtered pixel flagged as frame end");

  // A drain beat never updates the line buffers or echoes.
  a_flush_kind: assert property (@(posedge clk) disable iff (!rst_n)
    s1_ctl_r.flush |-> (!s1_ctl_r.wr && !s1_ctl_r.echo && s1_ctl_r.valid))
    else $error("inconsistent drain beat control");

  // The pipeline holds while the output is stalled.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(s3_ctl_r))
    else $error("pipeline moved during stall");

endmodule

### bench/tb_top.sv
// Self-checking bench for median_filter_3x3: a scoreboard class that predicts
// each result beat, and tasks that drive frames, flushes and register writes.
// Depends on the RTL package mf3_pkg and the top level median_filter_3x3.
`timescale 1ns / 1ps

typedef struct {
  logic [31:0] pix;
  bit          last;
} filtered_pix_t;

class median_check;
  // Register copies, as written (masked to register width).
  int unsigned frame_w = 640;
  int unsigned frame_h = 480;
  int unsigned chan_cnt = 4;
  // Line buffers, 3x3 window and position counters.
  logic [31:0] older_row [2048];
  logic [31:0] newer_row [2048];
  logic [31:0] win [9];
  int unsigned col_in, row_in, out_count;
  filtered_pix_t pending_pixels[$];
  int unsigned mismatches, results_seen;

  function new();
    foreach (win[i]) win[i] = '0;
    col_in = 0;
    row_in = 0;
    out_count = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [15:0] val);
    if (idx == mf3_pkg::REG_WIDTH) frame_w = 32'(val[11:0]);
    else if (idx == mf3_pkg::REG_HEIGHT) frame_h = 32'(val);
    else if (idx == mf3_pkg::REG_CHANNELS) chan_cnt = 32'(val[2:0]);
  endfunction

  function bit at_frame_start();
    return col_in == 0 && row_in == 0 && out_count == 0;
  endfunction

  function bit small_frame();
    return frame_w < 3 || frame_h < 3;
  endfunction

  function logic [7:0] median_of(int unsigned ch);
    logic [7:0] v [9];
    logic [7:0] t;
    for (int i = 0; i < 9; i++) v[i] = win[i][8*ch +: 8];
    for (int i = 1; i < 9; i++)
      for (int j = i; j > 0 && v[j-1] > v[j]; j--) begin
        t = v[j]; v[j] = v[j-1]; v[j-1] = t;
      end
    return v[4];
  endfunction

  // Called for every accepted input beat; queues the result it causes, if any.
  function void take_beat(bit flush, logic [31:0] px);
    int unsigned w, h, orow, ocol, x, y;
    bit last, emit;
    filtered_pix_t r;
    w = (frame_w > 2048) ? 2048 : frame_w;
    h = frame_h;
    if (w < 3 || h < 3) begin
      // Small frame: echo every pixel, flushes do nothing.
      if (flush) return;
      last = (col_in + 1 >= w) && (row_in + 1 >= h);
      col_in++;
      if (col_in >= w) begin
        col_in = 0;
        row_in++;
        if (row_in >= h) row_in = 0;
      end
      if (last) begin
        col_in = 0; row_in = 0;
      end
      out_count = 0;
      r.pix = px; r.last = last;
      pending_pixels.push_back(r);
      return;
    end
    orow = out_count / w;
    ocol = out_count % w;
    last = out_count + 1 >= w * h;
    if (flush) begin
      // Flushes only count once the whole frame is in.
      if (row_in < h) return;
      r.pix = (orow + 1 >= h) ? newer_row[ocol] : older_row[ocol];
    end else begin
      // Pixels arriving while the frame drains are dropped.
      if (row_in >= h) return;
      x = col_in;
      y = row_in;
      if (x >= w) begin
        x = 0; y++;
      end
      for (int i = 0; i < 6; i++) win[i] = win[i+3];
      win[6] = older_row[x];
      win[7] = newer_row[x];
      win[8] = px;
      older_row[x] = newer_row[x];
      newer_row[x] = px;
      emit = (y >= 1 && x >= 1) || y >= 2;
      x++;
      if (x >= w) begin
        x = 0; y++;
      end
      col_in = x;
      row_in = y;
      if (!emit) return;
      r.pix = win[4];
      if (orow != 0 && orow + 1 < h && ocol != 0 && ocol + 1 < w)
        for (int c = 0; c < 4; c++)
          if (c < chan_cnt) r.pix[8*c +: 8] = median_of(c);
    end
    out_count++;
    if (last) begin
      col_in = 0; row_in = 0; out_count = 0;
    end
    r.last = last;
    pending_pixels.push_back(r);
  endfunction

  // Compares an accepted result beat, field by field, with the oldest prediction.
  function void check_beat(logic [31:0] data, logic last);
    filtered_pix_t e;
    results_seen++;
    if (pending_pixels.size() == 0) begin
      $display("%0t: unexpected result beat data=%h last=%b", $time, data, last);
      mismatches++;
      return;
    end
    e = pending_pixels.pop_front();
    for (int c = 0; c < 4; c++)
      if (data[8*c +: 8] !== e.pix[8*c +: 8]) begin
        $display("%0t: channel %0d expected %h actual %h", $time, c,
                 e.pix[8*c +: 8], data[8*c +: 8]);
        mismatches++;
      end
    if (last !== e.last) begin
      $display("%0t: frame_last expected %b actual %b", $time, e.last, last);
      mismatches++;
    end
  endfunction
endclass

module tb_top;

  localparam int RESULT_LATENCY = 12;
  localparam bit KIND_PIXEL = 1'b0;
  localparam bit KIND_FLUSH = 1'b1;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [15:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // chan_zero, chan_one, chan_two, chan_three
  logic        in_tuser;   // kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;  // res_zero, res_one, res_two, res_three
  logic        out_tlast;  // frame_last

  median_check sb = new();
  int unsigned beats_sent;
  int unsigned frames_done;
  bit          calm;        // set for the closing stretch: no idling anywhere
  int unsigned out_stall = 0;

  median_filter_3x3 i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  always #1 clk = ~clk;

  // Result side: every accepted beat goes to the scoreboard, which is sampled
  // at the edge so the values seen are those the handshake used. The ready
  // line drops in random bursts.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_beat(out_tdata, out_tlast);
    if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      out_stall <= $urandom_range(0, 5);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // A random pixel: mostly full-range, sometimes drawn from a few levels so
  // that the sorting network sees plenty of ties.
  function automatic logic [31:0] rand_pixel();
    logic [31:0] p;
    p = $urandom;
    if ($urandom_range(0, 3) == 0)
      for (int c = 0; c < 4; c++) p[8*c +: 8] = 8'(8'h40 * $urandom_range(0, 3) + 8'h3f);
    return p;
  endfunction

  // Presents one beat and holds it until the block takes it. Valid stays high
  // from one beat to the next unless an idle burst is chosen.
  task automatic send_beat(bit kind, logic [31:0] px);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= px;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.take_beat(kind, px);
    beats_sent++;
  endtask

  // Waits until every predicted result has been seen, then lets the pipeline
  // settle in case beats that give no result are still inside.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY) @(posedge clk);
  endtask

  // Leaves the write enable high; the caller drops it after the last write.
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic set_frame(logic [15:0] w, logic [15:0] h, logic [15:0] ch);
    wait_idle();
    write_reg(mf3_pkg::REG_WIDTH, w);
    write_reg(mf3_pkg::REG_HEIGHT, h);
    write_reg(mf3_pkg::REG_CHANNELS, ch);
    cfg_we <= 1'b0;
  endtask

  // One full frame. With noise, stray flushes go in before the frame is
  // complete and stray pixels while it drains; both must be ignored.
  task automatic send_frame(bit noise);
    bit started;
    started = 1'b0;
    if (sb.small_frame()) begin
      while (!started || !sb.at_frame_start()) begin
        if (noise && $urandom_range(0, 5) == 0) send_beat(KIND_FLUSH, $urandom);
        send_beat(KIND_PIXEL, rand_pixel());
        started = 1'b1;
      end
    end else begin
      // Pixels until the last one of the frame is in, then drain with flushes.
      while (sb.row_in < sb.frame_h) begin
        if (noise && $urandom_range(0, 9) == 0) send_beat(KIND_FLUSH, $urandom);
        send_beat(KIND_PIXEL, rand_pixel());
      end
      while (!sb.at_frame_start()) begin
        if (noise && $urandom_range(0, 9) == 0) send_beat(KIND_PIXEL, rand_pixel());
        send_beat(KIND_FLUSH, $urandom);
      end
      if (noise) send_beat(KIND_FLUSH, $urandom);
    end
    frames_done++;
  endtask

  initial begin
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_addr   <= mf3_pkg::REG_WIDTH;
    cfg_wdata  <= '0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= KIND_PIXEL;
    calm       = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: smallest filtering frame with all-zero and all-one
    // samples, the median in all four channels, and stray flushes and pixels.
    set_frame(16'd3, 16'd3, 16'd4);
    send_beat(KIND_FLUSH, 32'hffff_ffff);
    for (int i = 0; i < 9; i++)
      send_beat(KIND_PIXEL, (i % 2) ? 32'hffff_ffff : 32'h0000_0000);
    send_beat(KIND_FLUSH, '0);
    send_beat(KIND_PIXEL, 32'h1234_5678);
    while (!sb.at_frame_start()) send_beat(KIND_FLUSH, '0);
    // No channel filtered, then a count above four.
    set_frame(16'd4, 16'd3, 16'd0);
    send_frame(1'b1);
    set_frame(16'd3, 16'd4, 16'd7);
    send_frame(1'b1);
    // Small frames: single pixel, zero width and zero height.
    set_frame(16'd1, 16'd1, 16'd1);
    send_beat(KIND_FLUSH, '0);
    send_beat(KIND_PIXEL, 32'hffff_ffff);
    set_frame(16'd0, 16'd3, 16'd2);
    send_frame(1'b1);
    set_frame(16'd2, 16'd0, 16'd3);
    send_frame(1'b1);

    // A wider filtered frame, and a tall one-pixel-wide echoed frame.
    set_frame(16'd40, 16'd3, 16'd4);
    send_frame(1'b0);
    set_frame(16'd1, 16'd300, 16'd4);
    send_frame(1'b0);

    // Random part: mostly small well-formed frames under varied settings,
    // with some noisy ones. The last stretch runs with no idling.
    while (beats_sent < 2000) begin
      if (beats_sent > 1700) calm = 1'b1;
      if ($urandom_range(0, 5) == 0)
        set_frame(16'($urandom_range(0, 2)), 16'($urandom_range(1, 5)),
                  16'($urandom_range(0, 7)));
      else
        set_frame(16'($urandom_range(3, 9)), 16'($urandom_range(3, 6)),
                  16'($urandom_range(0, 7)));
      repeat ($urandom_range(1, 3)) send_frame($urandom_range(0, 3) == 0);
    end
    calm = 1'b1;

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY) @(posedge clk);
    $display("Sent %0d beats in %0d frames, checked %0d result beats.",
             beats_sent, frames_done, sb.results_seen);
    $display("Covered filtered, echoed and drained frames with stray beats.");
    if (sb.mismatches == 0 && sb.pending_pixels.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #4000000;
    $display("Timeout with %0d results outstanding.", sb.pending_pixels.size());
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

### filelist.f
rtl/mf3_pkg.sv
rtl/mf3_ram.sv
rtl/median_filter_3x3.sv
bench/tb_top.sv
